[rtl/kct_pkg.sv]
// kct_pkg: payload structs, command struct and opcode codes for the keyed count table.
// Used by every module of the block; depends on nothing.
package kct_pkg;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_REM_KEY  = 3'd1;
    localparam logic [2:0] OP_REM_SLOT = 3'd2;
    localparam logic [2:0] OP_LOOKUP   = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    localparam logic [4:0] SLOT_LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] item_key;
        logic [15:0] amount;
        logic [3:0]  slot_number;
    } kct_in_t;

    typedef struct packed {
        logic        ok;
        logic        found;
        logic [3:0]  slot_found;
        logic [15:0] count_out;
        logic [15:0] key_out;
        logic        has_enough;
        logic        saturated;
        logic [4:0]  entries_used;
        logic        full_res;
    } kct_out_t;

    typedef struct packed {
        logic load;
        logic commit;
    } kct_cmd_t;

endpackage

[rtl/keyed_count_table_core.sv]
// keyed_count_table_core: top level of the keyed count table.
// Depends on kct_pkg, kct_ctrl and kct_datapath.
//
// In the cycle a transfer is taken the key is compared against every occupied
// entry and the match vector is registered; after that the matching or addressed
// entry is updated (with shift-down on erase) and the result is loaded into the
// output register. The next transfer is taken the cycle after that update. If
// the previous result is still stalled at the output, the update waits until the
// output register frees. Table holds at most TABLE_DEPTH entries; slot_limit
// resets to 16 and is written through cfg_we.
module keyed_count_table_core
    import kct_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16,
    parameter int COUNT_BITS  = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  kct_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output kct_out_t   out_data,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata
);

    kct_cmd_t cmd;

    kct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    kct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_data  (out_data)
    );

endmodule

[rtl/kct_ctrl.sv]
// kct_ctrl: two-state controller for the keyed count table; owns the handshakes.
// Depends on kct_pkg for the command struct.
module kct_ctrl
    import kct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output kct_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.load   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.commit = (state_reg == ST_EXEC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/kct_datapath.sv]
// kct_datapath: entry registers, key match vector, update logic and result register.
// Depends on kct_pkg; driven by the command struct from kct_ctrl.
module kct_datapath
    import kct_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16,
    parameter int COUNT_BITS  = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  kct_cmd_t   cmd,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  kct_in_t    in_data,
    output kct_out_t   out_data
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int KIN_W  = (KEY_BITS < 16) ? KEY_BITS : 16;
    localparam int SUM_W  = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [KEY_BITS-1:0]   keys_reg   [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   keys_next  [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] counts_reg [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] counts_next[TABLE_DEPTH];
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      used_next;
    logic [4:0]            slot_limit_reg;
    logic [TABLE_DEPTH-1:0] match_reg;
    logic [TABLE_DEPTH-1:0] match_next;
    logic [2:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [15:0]           amt_reg;
    logic [3:0]            pos_reg;
    kct_out_t              res_reg;
    kct_out_t              res_next;

    logic [KEY_BITS-1:0]   key_in;
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      pos_idx;
    logic [IDX_W-1:0]      sel_idx;
    logic [IDX_W-1:0]      used_idx;
    logic [COUNT_BITS-1:0] sel_cnt;
    logic [KEY_BITS-1:0]   sel_key;
    logic                  pos_ok;
    logic                  amt_nz;
    logic                  full_now;
    logic [SUM_W-1:0]      amt_w;
    logic [SUM_W-1:0]      cnt_w;
    logic [SUM_W-1:0]      max_w;
    logic [SUM_W-1:0]      sum_w;
    logic [SUM_W-1:0]      diff_w;
    logic [SUM_W-1:0]      lk_w;
    logic                  add_sat;
    logic                  new_sat;
    logic                  short_cnt;
    logic [COUNT_BITS-1:0] diff_cnt;
    logic                  take;
    logic [SUM_W-1:0]      rep_cnt;
    logic [31:0]           used_wide;
    logic [31:0]           slot_wide;
    logic [31:0]           cnt_wide;
    logic [31:0]           key_wide;

    assign key_in = KEY_BITS'(in_data.item_key[KIN_W-1:0]);

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_next[i] = (CNT_W'(i) < used_reg) && (keys_reg[i] == key_in);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit      = |match_reg;
    assign pos_idx  = IDX_W'(pos_reg);
    assign used_idx = IDX_W'(used_reg);
    assign sel_idx  = (op_reg inside {OP_REM_SLOT, OP_READ}) ? pos_idx : hit_idx;
    assign sel_cnt  = counts_reg[sel_idx];
    assign sel_key  = keys_reg[sel_idx];
    assign pos_ok   = (32'(pos_reg) < 32'(used_reg)) && (32'(pos_reg) < TABLE_DEPTH);
    assign amt_nz   = (amt_reg != 16'd0);
    assign full_now = (32'(used_reg) >= 32'(slot_limit_reg)) ||
                      (32'(used_reg) >= TABLE_DEPTH);

    assign amt_w     = SUM_W'(amt_reg);
    assign cnt_w     = SUM_W'(sel_cnt);
    assign max_w     = SUM_W'(COUNT_MAX);
    assign sum_w     = cnt_w + amt_w;
    assign diff_w    = cnt_w - amt_w;
    assign add_sat   = (sum_w > max_w);
    assign new_sat   = (amt_w > max_w);
    assign short_cnt = (cnt_w < amt_w);
    assign diff_cnt  = diff_w[COUNT_BITS-1:0];
    assign lk_w      = hit ? cnt_w : '0;

    always_comb
    begin
        keys_next   = keys_reg;
        counts_next = counts_reg;
        used_next   = used_reg;
        res_next    = '0;
        take        = 1'b0;
        rep_cnt     = '0;
        key_wide    = '0;
        slot_wide   = '0;
        case (op_reg)
            OP_ADD:
            begin
                if (amt_nz && hit)
                begin
                    counts_next[sel_idx] = add_sat ? COUNT_MAX : sum_w[COUNT_BITS-1:0];
                    res_next.ok          = 1'b1;
                    res_next.saturated   = add_sat;
                end
                else if (amt_nz && !full_now)
                begin
                    keys_next[used_idx]   = key_reg;
                    counts_next[used_idx] = new_sat ? COUNT_MAX : amt_w[COUNT_BITS-1:0];
                    used_next             = used_reg + CNT_W'(1);
                    res_next.ok           = 1'b1;
                    res_next.saturated    = new_sat;
                end
            end
            OP_REM_KEY:
            begin
                take = amt_nz && hit && !short_cnt;
            end
            OP_REM_SLOT:
            begin
                take = amt_nz && pos_ok && !short_cnt;
            end
            OP_LOOKUP:
            begin
                res_next.found      = hit;
                slot_wide           = 32'(hit_idx);
                rep_cnt             = lk_w;
                res_next.has_enough = (lk_w >= amt_w);
            end
            OP_READ:
            begin
                if (pos_ok)
                begin
                    res_next.ok = 1'b1;
                    rep_cnt     = cnt_w;
                    key_wide    = 32'(sel_key);
                end
            end
            OP_CLEAR:
            begin
                used_next   = '0;
                res_next.ok = 1'b1;
            end
            default:
            begin
                res_next.ok = 1'b0;
            end
        endcase

        if (take)
        begin
            res_next.ok = 1'b1;
            if (diff_cnt == '0)
            begin
                for (int i = 0; i < TABLE_DEPTH - 1; i++)
                begin
                    if (IDX_W'(i) >= sel_idx)
                    begin
                        keys_next[i]   = keys_reg[i + 1];
                        counts_next[i] = counts_reg[i + 1];
                    end
                end
                used_next = used_reg - CNT_W'(1);
            end
            else
            begin
                counts_next[sel_idx] = diff_cnt;
            end
        end

        cnt_wide              = 32'(rep_cnt);
        used_wide             = 32'(used_next);
        res_next.slot_found   = slot_wide[3:0];
        res_next.count_out    = cnt_wide[15:0];
        res_next.key_out      = key_wide[15:0];
        res_next.entries_used = used_wide[4:0];
        res_next.full_res     = (used_wide >= 32'(slot_limit_reg)) ||
                                (used_wide >= TABLE_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            slot_limit_reg <= SLOT_LIMIT_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                used_reg <= used_next;
            end
            if (cfg_we)
            begin
                slot_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            match_reg <= match_next;
            op_reg    <= in_data.opcode;
            key_reg   <= key_in;
            amt_reg   <= in_data.amount;
            pos_reg   <= in_data.slot_number;
        end
        if (cmd.commit)
        begin
            keys_reg   <= keys_next;
            counts_reg <= counts_next;
            res_reg    <= res_next;
        end
    end

    assign out_data = res_reg;

endmodule

[rtl/kct_checker.sv]
// kct_checker: port-level assertions for keyed_count_table_core, bound to the top level.
// Depends on kct_pkg for the payload structs.
module kct_checker
    import kct_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input kct_out_t   out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a transfer");

    a_sat_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |-> out_data.ok)
        else $error("saturation flagged on a failed operation");

    a_found_is_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.slot_found == 4'd0)
        else $error("slot reported without a match");

endmodule

bind keyed_count_table_core kct_checker u_kct_checker (.*);
